FILE: design/pixel_canvas_cell_glyph_engine_assert.svh
`ifndef PIXEL_CANVAS_CELL_GLYPH_ENGINE_ASSERT_SVH
`define PIXEL_CANVAS_CELL_GLYPH_ENGINE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define PCG_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define PCG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pcg_pkg.sv
package pcg_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 32;
  localparam int WORD_W = 8;

  // command codes
  localparam logic [2:0] CMD_SET     = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_TOGGLE  = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_RENDER  = 3'd4;
  localparam logic [2:0] CMD_CLR_ALL = 3'd5;

  // cell modes
  localparam logic [1:0] MODE_ASCII   = 2'd0;
  localparam logic [1:0] MODE_BRAILLE = 2'd1;
  localparam logic [1:0] MODE_BLOCK   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [13:0] CP_BRAILLE = 14'h2800;
  localparam logic [13:0] CP_HASH    = 14'h0023;
  localparam logic [13:0] CP_SPACE   = 14'h0020;
  localparam logic [13:0] CP_ONE_BYTE_LIMIT = 14'h0080;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [1:0]  UTF8_LEN1  = 2'd1;
  localparam logic [1:0]  UTF8_LEN3  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_RD,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [6:0] char_columns;
    logic [5:0] char_rows;
    logic [1:0] cell_mode;
  } cfg_t;

  typedef struct packed {
    logic [4:0]        cell_row;
    logic [5:0]        cell_col;
    logic signed [8:0] y_coord;
    logic signed [8:0] x_coord;
    logic [2:0]        command;
  } req_t;

  typedef struct packed {
    logic       done;
    logic       is_read;
    logic       is_render;
    logic       pix;
    logic [3:0] left;
    logic [3:0] right;
  } seq_stat_t;

  typedef struct packed {
    logic [7:0]  utf8_byte2;
    logic [7:0]  utf8_byte1;
    logic [7:0]  utf8_byte0;
    logic [1:0]  utf8_length;
    logic [13:0] glyph_codepoint;
    logic        pixel_value;
  } res_t;

  // quadrant glyphs, index = {top left, top right, bottom left, bottom right}
  function automatic logic [13:0] quad_glyph(input logic [3:0] q);
    logic [13:0] cp;
    case (q)
      4'd0:    cp = 14'h0020;
      4'd1:    cp = 14'h2597;
      4'd2:    cp = 14'h2596;
      4'd3:    cp = 14'h2584;
      4'd4:    cp = 14'h259D;
      4'd5:    cp = 14'h2590;
      4'd6:    cp = 14'h259E;
      4'd7:    cp = 14'h259F;
      4'd8:    cp = 14'h2598;
      4'd9:    cp = 14'h259A;
      4'd10:   cp = 14'h258C;
      4'd11:   cp = 14'h2599;
      4'd12:   cp = 14'h2580;
      4'd13:   cp = 14'h259C;
      4'd14:   cp = 14'h259B;
      default: cp = 14'h2588;
    endcase
    return cp;
  endfunction

endpackage

FILE: design/pcg_bitmap_ram.sv
module pcg_bitmap_ram
  import pcg_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pcg_glyph_unit.sv
module pcg_glyph_unit
  import pcg_pkg::*;
(
  input  seq_stat_t  stat,
  input  logic [1:0] cell_mode,
  output res_t       res
);

  logic [13:0] cp;
  logic [3:0]  q;

  always_comb begin
    q = {stat.left[0], stat.right[0], stat.left[1], stat.right[1]};
    case (cell_mode)
      MODE_BRAILLE: begin
        cp = CP_BRAILLE | {6'd0, stat.right[3], stat.left[3], stat.right[2],
                           stat.right[1], stat.right[0], stat.left[2],
                           stat.left[1], stat.left[0]};
      end
      MODE_BLOCK: begin
        cp = quad_glyph(q);
      end
      default: begin
        cp = stat.left[0] ? CP_HASH : CP_SPACE;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (stat.is_read) begin
      res.pixel_value = stat.pix;
    end else if (stat.is_render) begin
      res.glyph_codepoint = cp;
      if (cp < CP_ONE_BYTE_LIMIT) begin
        res.utf8_length = UTF8_LEN1;
        res.utf8_byte0  = cp[7:0];
      end else begin
        res.utf8_length = UTF8_LEN3;
        res.utf8_byte0  = UTF8_LEAD3 | {6'd0, cp[13:12]};
        res.utf8_byte1  = UTF8_CONT | {2'd0, cp[11:6]};
        res.utf8_byte2  = UTF8_CONT | {2'd0, cp[5:0]};
      end
    end
  end

endmodule

FILE: design/pcg_sequencer.sv
module pcg_sequencer
  import pcg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              req,
  input  logic              take,
  output seq_stat_t         stat,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [WORD_W-1:0] wdata,
  output logic [AW-1:0]     raddr,
  input  logic [WORD_W-1:0] rdata
);

  `include "pixel_canvas_cell_glyph_engine_assert.svh"

  localparam int WORDS = MAX_COLS * MAX_ROWS;
  localparam int IW = AW + 3;
  localparam logic [AW-1:0] CLR_LAST = AW'(WORDS - 1);

  state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic              clr_cmd;
  logic [2:0]        cmd;
  logic signed [8:0] xin;
  logic signed [8:0] yin;
  logic [5:0]        ccol;
  logic [4:0]        crow;
  logic              x_ok;
  logic              y_neg;
  logic [7:0]        row_y;
  logic [7:0]        xo;
  logic [15:0]       prod;
  logic [IW-1:0]     row_idx;
  logic [1:0]        row_cnt;
  logic [3:0]        left;
  logic [3:0]        right;
  logic              pix;

  // geometry from the registers
  logic [6:0] cols;
  logic [5:0] rows;
  logic       wide;
  logic [7:0] pw;
  logic [7:0] ph;
  logic [6:0] bx;
  logic [6:0] by;
  logic [1:0] last_row;

  logic       is_render;
  logic       is_write;
  logic       row_valid;
  logic [2:0] bsel;
  logic       bit_l;
  logic       bit_r;
  logic [7:0] mask;
  logic [7:0] mod_word;

  always_comb begin
    cols = (9'(cfg.char_columns) > 9'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.char_columns;
    rows = (9'(cfg.char_rows) > 9'(MAX_ROWS)) ? 6'(MAX_ROWS) : cfg.char_rows;
    wide = (cfg.cell_mode == MODE_BRAILLE) || (cfg.cell_mode == MODE_BLOCK);
    pw   = wide ? {cols, 1'b0} : {1'b0, cols};
    bx   = wide ? {ccol, 1'b0} : {1'b0, ccol};
    case (cfg.cell_mode)
      MODE_BRAILLE: begin
        ph       = {rows, 2'b00};
        by       = {crow, 2'b00};
        last_row = 2'd3;
      end
      MODE_BLOCK: begin
        ph       = {1'b0, rows, 1'b0};
        by       = {1'b0, crow, 1'b0};
        last_row = 2'd1;
      end
      default: begin
        ph       = {2'b00, rows};
        by       = {2'b00, crow};
        last_row = 2'd0;
      end
    endcase
  end

  always_comb begin
    is_render = (cmd == CMD_RENDER);
    is_write  = (cmd == CMD_SET) || (cmd == CMD_CLEAR) || (cmd == CMD_TOGGLE);
    row_valid = x_ok && !y_neg && (row_y < ph);
    bsel      = row_idx[2:0];
    bit_l     = rdata[bsel];
    bit_r     = rdata[bsel + 3'd1];
    mask      = 8'd1 << bsel;
    case (cmd)
      CMD_SET:    mod_word = rdata | mask;
      CMD_CLEAR:  mod_word = rdata & ~mask;
      CMD_TOGGLE: mod_word = rdata ^ mask;
      default:    mod_word = rdata;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = clr_cmd ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (req.command)
            CMD_CLR_ALL: state_next = ST_CLR;
            CMD_SET, CMD_CLEAR, CMD_TOGGLE, CMD_READ, CMD_RENDER: state_next = ST_CALC;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_CALC: state_next = ST_ADDR;
      ST_ADDR: state_next = ST_RD;
      ST_RD:   state_next = ST_MOD;
      ST_MOD: begin
        state_next = (is_render && (row_cnt != last_row)) ? ST_RD : ST_DONE;
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state == ST_IDLE);
    raddr          = row_idx[IW-1:3];
    we             = 1'b0;
    waddr          = row_idx[IW-1:3];
    wdata          = mod_word;
    stat.done      = (state == ST_DONE);
    stat.is_read   = (cmd == CMD_READ);
    stat.is_render = is_render;
    stat.pix       = pix;
    stat.left      = left;
    stat.right     = right;
    case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_MOD: begin
        we = row_valid && is_write;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end else if (state == ST_IDLE && in_valid) begin
        clr_addr <= '0;
        clr_cmd  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd   <= req.command;
          xin   <= req.x_coord;
          yin   <= req.y_coord;
          ccol  <= req.cell_col;
          crow  <= req.cell_row;
          left  <= '0;
          right <= '0;
          pix   <= 1'b0;
        end
      end
      ST_CALC: begin
        if (is_render) begin
          x_ok  <= (8'(bx) < pw);
          y_neg <= 1'b0;
          row_y <= 8'(by);
          xo    <= 8'(bx);
          prod  <= 8'(by) * pw;
        end else begin
          x_ok  <= !xin[8] && (xin[7:0] < pw);
          y_neg <= yin[8];
          row_y <= yin[7:0];
          xo    <= xin[7:0];
          prod  <= yin[7:0] * pw;
        end
      end
      ST_ADDR: begin
        row_idx <= IW'(prod + 16'(xo));
        row_cnt <= '0;
      end
      ST_MOD: begin
        pix            <= row_valid && bit_l;
        left[row_cnt]  <= row_valid && bit_l;
        right[row_cnt] <= row_valid && bit_r;
        if (is_render && (row_cnt != last_row)) begin
          row_cnt <= row_cnt + 2'd1;
          row_idx <= row_idx + IW'(pw);
          row_y   <= row_y + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  `PCG_ASSERT_NOW(a_we_src, clk, rst, we, (state == ST_CLR) || (state == ST_MOD), "write outside clear or modify")
  `PCG_ASSERT_NOW(a_clr_zero, clk, rst, state == ST_CLR, we && (wdata == '0), "clear sweep not writing zeros")
  `PCG_ASSERT_NOW(a_mod_after_rd, clk, rst, state == ST_MOD, $past(state) == ST_RD, "modify without a read before it")
  `PCG_ASSERT_NEXT(a_done_release, clk, rst, (state == ST_DONE) && take, state == ST_IDLE, "result taken but sequencer not idle")

endmodule

FILE: design/pixel_canvas_cell_glyph_engine.sv
// set/clear/toggle/read: calc, address, read and modify states; unknown codes answer directly
// render: a read and a modify per pixel row of the cell (1 row ascii, 2 block, 4 braille)
// clear all: one bitmap word per cycle over all MAX_COLS*MAX_ROWS words, then a result
// requests: one at a time through the single bitmap memory, the next accepted once the
// previous result has moved to the output register; a held result stalls the request side
// reset: synchronous, 64 cols, 32 rows, braille; then a sweep clears MAX_COLS*MAX_ROWS words
module pixel_canvas_cell_glyph_engine
  import pcg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], x_coord[11:3], y_coord[20:12], cell_col[26:21], cell_row[31:27]
  input  logic [31:0] s_axis_tdata,
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value[0], glyph_codepoint[14:1], utf8_length[16:15], utf8_byte0[24:17],
  // utf8_byte1[32:25], utf8_byte2[40:33], zero pad [47:41]
  output logic [47:0] m_axis_tdata,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // the bitmap is byte-wide: pixel index bits [2:0] pick the bit, the rest the word,
  // so both pixels of a two-wide cell row come from one read
  localparam int WORDS = MAX_COLS * MAX_ROWS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  cfg_t      cfg;
  req_t      req;
  seq_stat_t stat;
  res_t      res;
  res_t      out_res;
  logic      out_valid;
  logic      take;
  logic      cfg_wr;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // register port: no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_columns <= 7'd64;
      cfg.char_rows    <= 6'd32;
      cfg.cell_mode    <= MODE_BRAILLE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COLS: cfg.char_columns <= pwdata[6:0];
        REG_ROWS: cfg.char_rows    <= pwdata[5:0];
        REG_MODE: cfg.cell_mode    <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLS: prdata = 32'(cfg.char_columns);
      REG_ROWS: prdata = 32'(cfg.char_rows);
      REG_MODE: prdata = 32'(cfg.cell_mode);
      default:  prdata = '0;
    endcase
  end

  // request unpacking, fields from the lowest bit up
  assign req = req_t'(s_axis_tdata);

  pcg_sequencer #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .req      (req),
    .take     (take),
    .stat     (stat),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    (mem_wdata),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata)
  );

  pcg_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // codepoint and utf-8 bytes from the collected cell pixels
  pcg_glyph_unit u_glyph (
    .stat      (stat),
    .cell_mode (cfg.cell_mode),
    .res       (res)
  );

  // output register: a finished result moves here when the slot is free
  assign take = stat.done && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res.utf8_byte2, out_res.utf8_byte1, out_res.utf8_byte0,
                          out_res.utf8_length, out_res.glyph_codepoint, out_res.pixel_value};

endmodule

FILE: verif/pixel_canvas_cell_glyph_engine_checker.sv
module pixel_canvas_cell_glyph_engine_checker
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [31:0] req_data,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [47:0] res_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          results_due
);

  localparam int CANVAS_BITS = DEF_MAX_COLS * DEF_MAX_ROWS * 8;

  logic [6:0] cfg_cols;
  logic [5:0] cfg_rows;
  logic [1:0] cfg_mode;
  bit         canvas [CANVAS_BITS];
  res_t       glyph_due [$];
  res_t       want;
  res_t       got;

  function automatic void cell_dims(output int cw, output int ch);
    case (cfg_mode)
      MODE_BRAILLE: begin
        cw = 2;
        ch = 4;
      end
      MODE_BLOCK: begin
        cw = 2;
        ch = 2;
      end
      default: begin
        cw = 1;
        ch = 1;
      end
    endcase
  endfunction

  // true when (x,y) falls on the canvas, with its row-major bit index
  function automatic bit locate(input int x, input int y, output int idx);
    int cols, rows, cw, ch, pw, ph;
    cols = (cfg_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cfg_cols);
    rows = (cfg_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(cfg_rows);
    cell_dims(cw, ch);
    pw = cols * cw;
    ph = rows * ch;
    idx = y * pw + x;
    return (x >= 0) && (y >= 0) && (x < pw) && (y < ph);
  endfunction

  function automatic bit pixel_at(input int x, input int y);
    int idx;
    if (!locate(x, y, idx)) return 1'b0;
    return canvas[idx];
  endfunction

  // braille dot weights: dots 1-3 and 4-6 in the low bits, dots 7 and 8 on top
  function automatic logic [7:0] dot_weight(input int dx, input int dy);
    if (dy == 3) return (dx != 0) ? 8'h80 : 8'h40;
    return 8'(1 << (dx * 3 + dy));
  endfunction

  function automatic logic [13:0] quadrant_cp(input logic [3:0] q);
    logic [13:0] cp;
    case (q)
      4'd0:    cp = 14'h0020;
      4'd1:    cp = 14'h2597;
      4'd2:    cp = 14'h2596;
      4'd3:    cp = 14'h2584;
      4'd4:    cp = 14'h259D;
      4'd5:    cp = 14'h2590;
      4'd6:    cp = 14'h259E;
      4'd7:    cp = 14'h259F;
      4'd8:    cp = 14'h2598;
      4'd9:    cp = 14'h259A;
      4'd10:   cp = 14'h258C;
      4'd11:   cp = 14'h2599;
      4'd12:   cp = 14'h2580;
      4'd13:   cp = 14'h259C;
      4'd14:   cp = 14'h259B;
      default: cp = 14'h2588;
    endcase
    return cp;
  endfunction

  // applies one request to the shadow canvas and returns the response it owes
  function automatic res_t run_canvas_cmd(input req_t r);
    res_t        o;
    int          x, y, idx, cw, ch, bx, by, dx, dy;
    logic [13:0] cp;
    o = '0;
    cp = '0;
    x = int'(r.x_coord);
    y = int'(r.y_coord);
    case (r.command)
      CMD_SET, CMD_CLEAR, CMD_TOGGLE: begin
        if (locate(x, y, idx)) begin
          if (r.command == CMD_SET) canvas[idx] = 1'b1;
          else if (r.command == CMD_CLEAR) canvas[idx] = 1'b0;
          else canvas[idx] = !canvas[idx];
        end
      end
      CMD_READ: o.pixel_value = pixel_at(x, y);
      CMD_RENDER: begin
        cell_dims(cw, ch);
        bx = int'(r.cell_col) * cw;
        by = int'(r.cell_row) * ch;
        if (cfg_mode == MODE_BRAILLE) begin
          cp = CP_BRAILLE;
          for (dx = 0; dx < 2; dx++)
            for (dy = 0; dy < 4; dy++)
              if (pixel_at(bx + dx, by + dy)) cp = cp | {6'b0, dot_weight(dx, dy)};
        end else if (cfg_mode == MODE_BLOCK) begin
          cp = quadrant_cp({pixel_at(bx, by), pixel_at(bx + 1, by),
                            pixel_at(bx, by + 1), pixel_at(bx + 1, by + 1)});
        end else begin
          cp = pixel_at(bx, by) ? CP_HASH : CP_SPACE;
        end
        o.glyph_codepoint = cp;
        if (cp < CP_ONE_BYTE_LIMIT) begin
          o.utf8_length = UTF8_LEN1;
          o.utf8_byte0  = cp[7:0];
        end else begin
          o.utf8_length = UTF8_LEN3;
          o.utf8_byte0  = UTF8_LEAD3 | {6'b0, cp[13:12]};
          o.utf8_byte1  = UTF8_CONT | {2'b0, cp[11:6]};
          o.utf8_byte2  = UTF8_CONT | {2'b0, cp[5:0]};
        end
      end
      CMD_CLR_ALL: canvas = '{default: 1'b0};
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_cols = 7'd64;
      cfg_rows = 6'd32;
      cfg_mode = MODE_BRAILLE;
      canvas = '{default: 1'b0};
      glyph_due.delete();
      mismatches = 0;
      results_due <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_COLS: cfg_cols = pwdata[6:0];
          REG_ROWS: cfg_rows = pwdata[5:0];
          REG_MODE: cfg_mode = pwdata[1:0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (glyph_due.size() == 0) begin
          $error("response 0x%0h with no request outstanding", res_data);
          mismatches++;
        end else begin
          want = glyph_due.pop_front();
          got  = res_t'(res_data[40:0]);
          check_field("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
          check_field("glyph_codepoint", 32'(want.glyph_codepoint),
                      32'(got.glyph_codepoint));
          check_field("utf8_length", 32'(want.utf8_length), 32'(got.utf8_length));
          check_field("utf8_byte0", 32'(want.utf8_byte0), 32'(got.utf8_byte0));
          check_field("utf8_byte1", 32'(want.utf8_byte1), 32'(got.utf8_byte1));
          check_field("utf8_byte2", 32'(want.utf8_byte2), 32'(got.utf8_byte2));
          check_field("pad", 32'd0, 32'(res_data[47:41]));
        end
      end
      if (req_valid && req_ready) glyph_due.push_back(run_canvas_cmd(req_t'(req_data)));
      results_due <= glyph_due.size();
    end
  end

endmodule

FILE: verif/pixel_canvas_cell_glyph_engine_tb.sv
module pixel_canvas_cell_glyph_engine_tb;
  import pcg_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_NOP_A  = 3'd6;
  localparam logic [2:0] CMD_NOP_B  = 3'd7;
  // spare cell mode, behaves as ascii
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 105;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          results_due;

  // geometry the stimulus aims at, mirrors the last register writes
  int          geo_cols = 64;
  int          geo_rows = 32;
  logic [1:0]  geo_mode = MODE_BRAILLE;

  // sender burst state and the cell that drawing currently concentrates on
  int          burst_left = 0;
  int          focus_col = 0;
  int          focus_row = 0;
  int          focus_left = 0;

  // raised by stimulus, served and cleared by the receiver
  bit          hold_request = 1'b0;

  pixel_canvas_cell_glyph_engine uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pixel_canvas_cell_glyph_engine_checker canvas_watch (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_valid),
    .req_ready   (s_ready),
    .req_data    (s_data),
    .res_valid   (m_valid),
    .res_ready   (m_ready),
    .res_data    (m_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("pixel_canvas_cell_glyph_engine_tb: FAIL");
    $finish;
  end

  // receiver: stall style changes every so often, long hold-off on demand
  initial begin
    int style;
    int left;
    int k;
    style = 0;
    left = 0;
    k = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // hold off long enough that the block backs up into its request side
        hold_request = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(16, 200);
        end
        left--;
        k++;
        case (style)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          2: m_ready <= ($urandom_range(0, 5) == 0);
          default: m_ready <= k[2];
        endcase
      end
    end
  end

  function automatic req_t make_req(input logic [2:0] cmd, input int x, input int y,
                                    input int col, input int row);
    req_t r;
    r.command  = cmd;
    r.x_coord  = 9'(x);
    r.y_coord  = 9'(y);
    r.cell_col = 6'(col);
    r.cell_row = 5'(row);
    return r;
  endfunction

  // random request: mostly drawing inside one cell and rendering it, some noise
  function automatic req_t pick_req();
    req_t r;
    int   p, q, cols, rows, cw, ch, pw, ph;
    cols = (geo_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : geo_cols;
    rows = (geo_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : geo_rows;
    case (geo_mode)
      MODE_BRAILLE: begin
        cw = 2;
        ch = 4;
      end
      MODE_BLOCK: begin
        cw = 2;
        ch = 2;
      end
      default: begin
        cw = 1;
        ch = 1;
      end
    endcase
    pw = cols * cw;
    ph = rows * ch;
    if (focus_left == 0 && pw > 0 && ph > 0) begin
      focus_col = $urandom_range(0, cols - 1);
      focus_row = $urandom_range(0, rows - 1);
      focus_left = $urandom_range(4, 16);
    end
    if (focus_left > 0) focus_left--;
    // unused fields carry random bits
    r.x_coord  = 9'($urandom);
    r.y_coord  = 9'($urandom);
    r.cell_col = 6'($urandom);
    r.cell_row = 5'($urandom);
    p = $urandom_range(0, 99);
    if (p < 28) r.command = CMD_SET;
    else if (p < 40) r.command = CMD_CLEAR;
    else if (p < 52) r.command = CMD_TOGGLE;
    else if (p < 70) r.command = CMD_READ;
    else if (p < 94) r.command = CMD_RENDER;
    else if (p < 96) r.command = CMD_CLR_ALL;
    else if (p < 98) r.command = $urandom_range(0, 1) ? CMD_NOP_A : CMD_NOP_B;
    else r.command = 3'($urandom);
    q = $urandom_range(0, 99);
    if (q < 85 && pw > 0 && ph > 0) begin
      if (q < 60) begin
        r.x_coord  = 9'(focus_col * cw + $urandom_range(0, cw - 1));
        r.y_coord  = 9'(focus_row * ch + $urandom_range(0, ch - 1));
        r.cell_col = 6'(focus_col);
        r.cell_row = 5'(focus_row);
      end else begin
        r.x_coord  = 9'($urandom_range(0, pw - 1));
        r.y_coord  = 9'($urandom_range(0, ph - 1));
        r.cell_col = 6'($urandom_range(0, cols - 1));
        r.cell_row = 5'($urandom_range(0, rows - 1));
      end
    end
    return r;
  endfunction

  // present one request, with random gaps between bursts, and wait for it to be taken
  task automatic offer_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= r;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // stop offering and wait until every owed response has come back
  task automatic wait_drained(input int settle);
    s_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // back-to-back register writes, upper bits beyond each field are junk
  task automatic configure(input int cols, input int rows, input logic [1:0] mode);
    logic [31:0] vals [3];
    logic [1:0]  regs [3];
    int          widths [3];
    vals[0] = cols;
    vals[1] = rows;
    vals[2] = 32'(mode);
    regs[0] = REG_COLS;
    regs[1] = REG_ROWS;
    regs[2] = REG_MODE;
    widths[0] = 7;
    widths[1] = 6;
    widths[2] = 2;
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= vals[i] | (32'($urandom) << widths[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    geo_cols = cols;
    geo_rows = rows;
    geo_mode = mode;
    focus_left = 0;
  endtask

  // one geometry setting: reprogram while idle, optionally wipe, then random traffic
  task automatic run_phase(input int cols, input int rows, input logic [1:0] mode,
                           input bit wipe, input bit squeeze);
    wait_drained(8);
    configure(cols, rows, mode);
    if (wipe) offer_request(make_req(CMD_CLR_ALL, 0, 0, 0, 0));
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (squeeze && n == 30) hold_request = 1'b1;
      if (squeeze && n == 70) wait_drained(0);
      offer_request(pick_req());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed pass at the reset geometry: 64x32 braille cells, 128x128 pixels
    offer_request(make_req(CMD_SET, 0, 0, 63, 31));
    offer_request(make_req(CMD_SET, 127, 127, 0, 0));
    offer_request(make_req(CMD_SET, 1, 3, 0, 0));
    offer_request(make_req(CMD_TOGGLE, 0, 3, 0, 0));
    offer_request(make_req(CMD_TOGGLE, 1, 0, 0, 0));
    offer_request(make_req(CMD_TOGGLE, 1, 0, 0, 0));
    offer_request(make_req(CMD_RENDER, -1, -1, 0, 0));
    offer_request(make_req(CMD_RENDER, 0, 0, 63, 31));
    offer_request(make_req(CMD_READ, 127, 127, 0, 0));
    // off-canvas coordinates: writes dropped, reads give zero
    offer_request(make_req(CMD_READ, 128, 5, 0, 0));
    offer_request(make_req(CMD_READ, -1, 0, 0, 0));
    offer_request(make_req(CMD_SET, -256, -256, 0, 0));
    offer_request(make_req(CMD_SET, 255, 255, 0, 0));
    offer_request(make_req(CMD_TOGGLE, 0, 128, 0, 0));
    offer_request(make_req(CMD_READ, 0, -256, 0, 0));
    offer_request(make_req(CMD_CLEAR, 0, 0, 0, 0));
    offer_request(make_req(CMD_READ, 0, 0, 0, 0));
    offer_request(make_req(CMD_RENDER, 0, 0, 62, 30));
    // undefined codes do nothing and answer with zeros
    offer_request(make_req(CMD_NOP_A, -1, 255, 63, 31));
    offer_request(make_req(CMD_NOP_B, 5, 5, 0, 0));
    offer_request(make_req(CMD_CLR_ALL, 127, 127, 63, 31));
    offer_request(make_req(CMD_READ, 127, 127, 0, 0));
    offer_request(make_req(CMD_RENDER, 0, 0, 0, 0));

    // geometry sweep, extremes included; a few changes skip the wipe on purpose
    run_phase(4, 2, MODE_BRAILLE, 1'b1, 1'b1);
    run_phase(1, 1, MODE_ASCII, 1'b1, 1'b0);
    run_phase(127, 63, MODE_BLOCK, 1'b1, 1'b0);
    run_phase(6, 5, MODE_BLOCK, 1'b0, 1'b0);
    run_phase(0, 3, MODE_BRAILLE, 1'b1, 1'b0);
    run_phase(8, 0, MODE_ASCII, 1'b1, 1'b0);
    run_phase(10, 6, MODE_SPARE, 1'b1, 1'b0);
    run_phase(64, 32, MODE_ASCII, 1'b1, 1'b1);
    run_phase(3, 4, MODE_BLOCK, 1'b1, 1'b0);
    run_phase(2, 2, MODE_BRAILLE, 1'b1, 1'b0);
    run_phase(64, 32, MODE_BRAILLE, 1'b0, 1'b0);

    // let the last responses land, plus some margin
    wait_drained(32);
    if (mismatches == 0) begin
      $display("pixel_canvas_cell_glyph_engine_tb: PASS");
    end else begin
      $display("pixel_canvas_cell_glyph_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
